/* src/cpid_pkg.sv */
// Shared widths, constants and configuration types for the cascaded PID controller.
// Used by cpid_cfg_regs, cpid_mul and cascade_pid_controller; depends on nothing.
`default_nettype none

package cpid_pkg;

	// Fixed-point layout.
	localparam int GAIN_W         = 16;
	localparam int GAIN_FRAC_BITS = 8;
	localparam int ERR_W          = 32;
	localparam int DIFF_W         = ERR_W + 1;
	localparam int INT_W          = 34;
	localparam int MUL_A_W        = INT_W;
	localparam int PROD_W         = MUL_A_W + GAIN_W + 1;
	localparam int TERM_W         = PROD_W - GAIN_FRAC_BITS;
	localparam int ACC_W          = TERM_W + 2;
	localparam int OUT_W          = 16;
	localparam int LIM_W          = 15;
	localparam int DEAD_W         = 16;
	localparam int ILIM_W         = 32;

	// Encoder turn used when folding the outer error.
	localparam int ENCODER_PERIOD = 8191;
	localparam int FOLD1_PERIOD   = ENCODER_PERIOD;
	localparam int FOLD1_LIM      = FOLD1_PERIOD / 2;
	localparam int FOLD2_PERIOD   = ENCODER_PERIOD / 2;
	localparam int FOLD2_LIM      = FOLD2_PERIOD / 2;

	// Stream and configuration port widths.
	localparam int IN_DATA_W   = 80;
	localparam int OUT_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 48;

	// Per-loop settings as decoded from the register file.
	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic [DEAD_W-1:0] dead;
		logic [ILIM_W-1:0] ilim;
		logic [LIM_W-1:0]  itlim;
		logic [LIM_W-1:0]  outlim;
	} loop_cfg_t;

	typedef struct packed {
		loop_cfg_t   outer;
		loop_cfg_t   inner;
		logic        cascade;
		logic [1:0]  wrap_mode;
	} cfg_t;

endpackage

`default_nettype wire

/* src/cascade_pid_controller.sv */
// Cascaded positional PID controller. Each input transaction carries a target, an outer
// measurement and an inner measurement; one output transaction returns the drive command
// and the clamped outer loop output. A sequencer runs every loop step through a single
// shared multiplier, three products per loop, running the inner loop after the outer one
// only with the cascade on. s_tready rises again together with the output valid, so a new
// item is taken only once the last result has entered the output register. A result that the
// receiver does not take yet holds the sequencer until the output register frees up.
// A finished result sits in the output register while the next item is accepted.
// s_tready is also held low while a configuration write is offered, so a write never meets
// an item on the same edge. Any configuration write clears both loops' integral and last
// error.
// Depends on cpid_pkg, cpid_cfg_regs and cpid_mul.
`default_nettype none

module cascade_pid_controller (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// s_tdata: target[31:0], outer_measure[63:32], inner_measure[79:64]
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [cpid_pkg::IN_DATA_W-1:0]      s_tdata,
	// m_tdata: drive[15:0], outer_output[31:16]
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [cpid_pkg::OUT_DATA_W-1:0]          m_tdata,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [cpid_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [cpid_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ERR   = 4'd1;
	localparam logic [3:0] ST_FOLD1 = 4'd2;
	localparam logic [3:0] ST_FOLD2 = 4'd3;
	localparam logic [3:0] ST_DEAD  = 4'd4;
	localparam logic [3:0] ST_MULP  = 4'd5;
	localparam logic [3:0] ST_MULI  = 4'd6;
	localparam logic [3:0] ST_MULD  = 4'd7;
	localparam logic [3:0] ST_SUM   = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	localparam logic [1:0] WRAP_NONE = 2'd0;
	localparam logic [1:0] WRAP_FULL = 2'd1;
	localparam logic [1:0] WRAP_HALF = 2'd2;

	localparam int ERR_W  = cpid_pkg::ERR_W;
	localparam int INT_W  = cpid_pkg::INT_W;
	localparam int DIFF_W = cpid_pkg::DIFF_W;
	localparam int ACC_W  = cpid_pkg::ACC_W;
	localparam int OUT_W  = cpid_pkg::OUT_W;

	localparam logic signed [ERR_W-1:0] F1_PERIOD = ERR_W'(cpid_pkg::FOLD1_PERIOD);
	localparam logic signed [ERR_W-1:0] F1_LIM    = ERR_W'(cpid_pkg::FOLD1_LIM);
	localparam logic signed [ERR_W-1:0] F2_PERIOD = ERR_W'(cpid_pkg::FOLD2_PERIOD);
	localparam logic signed [ERR_W-1:0] F2_LIM    = ERR_W'(cpid_pkg::FOLD2_LIM);

	cpid_pkg::cfg_t      cfg;
	cpid_pkg::loop_cfg_t lcfg;

	logic [3:0] state_q;
	logic       loop_inner_q;

	logic signed [ERR_W-1:0]  tgt_q, om_q;
	logic signed [OUT_W-1:0]  im_q;
	logic signed [ERR_W-1:0]  e_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [OUT_W-1:0]  oout_q, res_q;

	logic signed [INT_W-1:0]  outer_integral_q, inner_integral_q;
	logic signed [ERR_W-1:0]  outer_last_q, inner_last_q;

	logic                     m_tvalid_q;
	logic [cpid_pkg::OUT_DATA_W-1:0] m_tdata_q;

	logic                     in_fire, cfg_fire, out_load;
	logic signed [INT_W-1:0]  cur_integral;
	logic signed [ERR_W-1:0]  cur_last;
	logic signed [DIFF_W-1:0] raw_err, e_mag;
	logic signed [ERR_W-1:0]  sat_err, e_dead;
	logic signed [INT_W:0]    int_sum, int_lim;
	logic signed [INT_W-1:0]  int_next;
	logic signed [ACC_W-1:0]  term_ext, sum_full;
	logic signed [OUT_W-1:0]  loop_res;
	logic signed [OUT_W:0]    inner_err;

	logic                                mul_en;
	logic signed [cpid_pkg::MUL_A_W-1:0] mul_a;
	logic        [cpid_pkg::GAIN_W-1:0]  mul_b;
	logic signed [cpid_pkg::TERM_W-1:0]  mul_term;

	// Moves an error one period toward zero when it lies beyond half a period.
	function automatic logic signed [ERR_W-1:0] fold_err(
		input logic signed [ERR_W-1:0] e,
		input logic signed [ERR_W-1:0] period,
		input logic signed [ERR_W-1:0] lim
	);
		logic signed [ERR_W-1:0] r;
		r = e;
		if (e > lim) begin
			r = e - period;
		end else if (e < -lim) begin
			r = e + period;
		end
		return r;
	endfunction

	// Symmetric clamp of an accumulator value to a 15-bit limit.
	function automatic logic signed [ACC_W-1:0] clamp_acc(
		input logic signed [ACC_W-1:0]   v,
		input logic [cpid_pkg::LIM_W-1:0] lim
	);
		logic signed [ACC_W-1:0] l;
		logic signed [ACC_W-1:0] r;
		l = $signed(ACC_W'(lim));
		r = v;
		if (v > l) begin
			r = l;
		end else if (v < -l) begin
			r = -l;
		end
		return r;
	endfunction

	cpid_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_fire),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	cpid_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.op_a (mul_a),
		.op_b (mul_b),
		.term (mul_term)
	);

	assign s_tready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// Settings and state of the loop being worked on.
	assign lcfg         = loop_inner_q ? cfg.inner : cfg.outer;
	assign cur_integral = loop_inner_q ? inner_integral_q : outer_integral_q;
	assign cur_last     = loop_inner_q ? inner_last_q : outer_last_q;

	// Error arithmetic: saturated difference, deadband and clamped integral.
	always_comb begin
		raw_err = {tgt_q[ERR_W-1], tgt_q} - {om_q[ERR_W-1], om_q};
		if (raw_err[DIFF_W-1] != raw_err[DIFF_W-2]) begin
			sat_err = raw_err[DIFF_W-1] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
		end else begin
			sat_err = raw_err[ERR_W-1:0];
		end
		e_mag = e_q[ERR_W-1] ? -{e_q[ERR_W-1], e_q} : {e_q[ERR_W-1], e_q};
		e_dead = ($unsigned(e_mag) <= DIFF_W'(lcfg.dead)) ? '0 : e_q;
		int_sum = {cur_integral[INT_W-1], cur_integral} + (INT_W+1)'(e_dead);
		int_lim = $signed((INT_W+1)'(lcfg.ilim));
		if (int_sum > int_lim) begin
			int_next = int_lim[INT_W-1:0];
		end else if (int_sum < -int_lim) begin
			int_next = INT_W'(-int_lim);
		end else begin
			int_next = int_sum[INT_W-1:0];
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_en = 1'b0;
		mul_a  = cpid_pkg::MUL_A_W'(e_q);
		mul_b  = lcfg.kp;
		unique case (state_q)
			ST_MULP: begin
				mul_en = 1'b1;
			end
			ST_MULI: begin
				mul_en = 1'b1;
				mul_a  = cur_integral;
				mul_b  = lcfg.ki;
			end
			ST_MULD: begin
				mul_en = 1'b1;
				mul_a  = cpid_pkg::MUL_A_W'(diff_q);
				mul_b  = lcfg.kd;
			end
			default: begin
			end
		endcase
	end

	// Term accumulation and output clamp.
	assign term_ext  = ACC_W'(mul_term);
	assign sum_full  = acc_q + term_ext;
	assign loop_res  = OUT_W'(clamp_acc(sum_full, lcfg.outlim));
	assign inner_err = {loop_res[OUT_W-1], loop_res} - {im_q[OUT_W-1], im_q};

	// Sequencer and loop state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			loop_inner_q     <= 1'b0;
			outer_integral_q <= '0;
			inner_integral_q <= '0;
			outer_last_q     <= '0;
			inner_last_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_fire) begin
						outer_integral_q <= '0;
						inner_integral_q <= '0;
						outer_last_q     <= '0;
						inner_last_q     <= '0;
					end
					if (in_fire) begin
						loop_inner_q <= 1'b0;
						state_q      <= ST_ERR;
					end
				end
				ST_ERR: begin
					state_q <= ST_FOLD1;
				end
				ST_FOLD1: begin
					state_q <= ST_FOLD2;
				end
				ST_FOLD2: begin
					state_q <= ST_DEAD;
				end
				ST_DEAD: begin
					if (loop_inner_q) begin
						inner_integral_q <= int_next;
						inner_last_q     <= e_dead;
					end else begin
						outer_integral_q <= int_next;
						outer_last_q     <= e_dead;
					end
					state_q <= ST_MULP;
				end
				ST_MULP: begin
					state_q <= ST_MULI;
				end
				ST_MULI: begin
					state_q <= ST_MULD;
				end
				ST_MULD: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (!loop_inner_q && cfg.cascade) begin
						loop_inner_q <= 1'b1;
						state_q      <= ST_DEAD;
					end else begin
						loop_inner_q <= 1'b0;
						state_q      <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			tgt_q <= s_tdata[31:0];
			om_q  <= s_tdata[63:32];
			im_q  <= s_tdata[79:64];
		end
		case (state_q)
			ST_ERR: begin
				e_q <= sat_err;
			end
			ST_FOLD1: begin
				if (cfg.wrap_mode == WRAP_FULL || cfg.wrap_mode == WRAP_HALF) begin
					e_q <= fold_err(e_q, F1_PERIOD, F1_LIM);
				end
			end
			ST_FOLD2: begin
				if (cfg.wrap_mode == WRAP_HALF) begin
					e_q <= fold_err(e_q, F2_PERIOD, F2_LIM);
				end
			end
			ST_DEAD: begin
				e_q    <= e_dead;
				diff_q <= {e_dead[ERR_W-1], e_dead} - {cur_last[ERR_W-1], cur_last};
			end
			ST_MULI: begin
				acc_q <= term_ext;
			end
			ST_MULD: begin
				acc_q <= acc_q + clamp_acc(term_ext, lcfg.itlim);
			end
			ST_SUM: begin
				res_q <= loop_res;
				if (!loop_inner_q) begin
					oout_q <= loop_res;
					e_q    <= ERR_W'(inner_err);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register; the next item may be taken while a result waits here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {oout_q, res_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// An accepted item keeps the input side closed on the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("input accepted again right after a transaction");

	// The inner loop only runs when cascade mode is enabled.
	assert property (@(posedge clk) disable iff (!arst_n)
		loop_inner_q |-> cfg.cascade)
		else $error("inner loop active with cascade disabled");

	// Both output fields are clamped symmetrically, so the most negative code never appears.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000))
		else $error("output outside the clamp range");

endmodule

`default_nettype wire

/* src/cpid_cfg_regs.sv */
// Configuration register file: decodes indexed writes into per-loop settings.
// Depends on cpid_pkg for the field widths and the cfg_t structure.
`default_nettype none

module cpid_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [cpid_pkg::CFG_INDEX_W-1:0] wr_index,
	input  wire logic [cpid_pkg::CFG_DATA_W-1:0]  wr_data,
	output cpid_pkg::cfg_t                        cfg
);

	localparam logic [cpid_pkg::CFG_INDEX_W-1:0] REG_OUTER_GAINS   = 3'd0;
	localparam logic [cpid_pkg::CFG_INDEX_W-1:0] REG_OUTER_ERR_LIM = 3'd1;
	localparam logic [cpid_pkg::CFG_INDEX_W-1:0] REG_OUTER_OUT_LIM = 3'd2;
	localparam logic [cpid_pkg::CFG_INDEX_W-1:0] REG_INNER_GAINS   = 3'd3;
	localparam logic [cpid_pkg::CFG_INDEX_W-1:0] REG_INNER_ERR_LIM = 3'd4;
	localparam logic [cpid_pkg::CFG_INDEX_W-1:0] REG_INNER_OUT_LIM = 3'd5;
	localparam logic [cpid_pkg::CFG_INDEX_W-1:0] REG_CASCADE       = 3'd6;
	localparam logic [cpid_pkg::CFG_INDEX_W-1:0] REG_WRAP_MODE     = 3'd7;

	cpid_pkg::cfg_t cfg_q;

	// Limits above 32767 act as 32767, so they are stored already saturated.
	function automatic logic [cpid_pkg::LIM_W-1:0] sat_lim(input logic [15:0] v);
		return v[15] ? {cpid_pkg::LIM_W{1'b1}} : v[cpid_pkg::LIM_W-1:0];
	endfunction

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OUTER_GAINS: begin
					cfg_q.outer.kp <= wr_data[15:0];
					cfg_q.outer.ki <= wr_data[31:16];
					cfg_q.outer.kd <= wr_data[47:32];
				end
				REG_OUTER_ERR_LIM: begin
					cfg_q.outer.dead <= wr_data[15:0];
					cfg_q.outer.ilim <= wr_data[47:16];
				end
				REG_OUTER_OUT_LIM: begin
					cfg_q.outer.itlim  <= sat_lim(wr_data[15:0]);
					cfg_q.outer.outlim <= sat_lim(wr_data[31:16]);
				end
				REG_INNER_GAINS: begin
					cfg_q.inner.kp <= wr_data[15:0];
					cfg_q.inner.ki <= wr_data[31:16];
					cfg_q.inner.kd <= wr_data[47:32];
				end
				REG_INNER_ERR_LIM: begin
					cfg_q.inner.dead <= wr_data[15:0];
					cfg_q.inner.ilim <= wr_data[47:16];
				end
				REG_INNER_OUT_LIM: begin
					cfg_q.inner.itlim  <= sat_lim(wr_data[15:0]);
					cfg_q.inner.outlim <= sat_lim(wr_data[31:16]);
				end
				REG_CASCADE: begin
					cfg_q.cascade <= wr_data[0];
				end
				REG_WRAP_MODE: begin
					cfg_q.wrap_mode <= wr_data[1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* src/cpid_mul.sv */
// Shared signed-by-gain multiplier with a registered product and floor scaling.
// Depends on cpid_pkg for operand, product and term widths.
`default_nettype none

module cpid_mul (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic signed [cpid_pkg::MUL_A_W-1:0] op_a,
	input  wire logic        [cpid_pkg::GAIN_W-1:0]  op_b,
	output logic signed      [cpid_pkg::TERM_W-1:0]  term
);

	logic signed [cpid_pkg::PROD_W-1:0] prod_q;

	// Gain is unsigned Q8.8, so it gets a zero sign bit before the multiply.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * $signed({1'b0, op_b});
		end
	end

	// Dropping the fraction bits of a two's complement value floors toward minus infinity.
	assign term = prod_q[cpid_pkg::PROD_W-1:cpid_pkg::GAIN_FRAC_BITS];

endmodule

`default_nettype wire

/* verif/tb_cascade_pid_controller.sv */
// Self-checking testbench for the cascaded PID controller: a directed table, then random
// phases with fresh register settings, checked by the table or an in-bench predictor.
// Depends on cpid_pkg and cascade_pid_controller.

module tb_cascade_pid_controller;

	import cpid_pkg::*;

	localparam int CYCLE_LIMIT     = 600000;
	localparam int SETTLE_CYCLES   = 40;
	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int REPORT_LIMIT    = 10;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_OUTER_GAINS,
		REG_OUTER_ERR_LIM,
		REG_OUTER_OUT_LIM,
		REG_INNER_GAINS,
		REG_INNER_ERR_LIM,
		REG_INNER_OUT_LIM,
		REG_CASCADE,
		REG_WRAP_MODE
	} cfg_reg_e;

	typedef enum logic [1:0] {
		WRAP_NONE,
		WRAP_TURN,
		WRAP_HALF_TURN,
		WRAP_SPARE
	} wrap_mode_e;

	typedef enum logic {
		ROW_WRITE,
		ROW_ITEM
	} row_kind_e;

	// Result fields, drive in the low half as on m_tdata.
	typedef struct packed {
		logic signed [OUT_W-1:0] outer_output;
		logic signed [OUT_W-1:0] drive;
	} drive_result_t;

	typedef struct packed {
		row_kind_e               kind;
		cfg_reg_e                reg_idx;
		logic [CFG_DATA_W-1:0]   value;
		logic signed [31:0]      target;
		logic signed [31:0]      outer_measure;
		logic signed [15:0]      inner_measure;
		logic                    known;
		drive_result_t           want;
	} stim_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	// Predictor copy of the register file and of both loops' state.
	logic [CFG_DATA_W-1:0]   cfg_shadow [8];
	longint                  outer_integral;
	longint                  outer_last_err;
	longint                  inner_integral;
	longint                  inner_last_err;

	drive_result_t           expected_drive_q [$];
	stim_row_t               directed_rows [$];
	int                      mismatch_count = 0;
	int                      cycle_count = 0;
	int                      burst_left = 0;
	logic [15:0]             ready_pattern = 16'hFFFF;
	logic [5:0]              pattern_age = '0;

	cascade_pid_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Symmetric saturation to plus or minus a limit.
	function automatic longint sym_limit(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Moves the error by one period toward zero once it exceeds half a period.
	function automatic longint fold_turn(input longint e, input longint period);
		longint mag;
		mag = (e < 0) ? -e : e;
		if (2 * mag > period)
			return (e >= 0) ? e - period : e + period;
		return e;
	endfunction

	// One positional PID update; the arithmetic shift floors each term.
	function automatic longint loop_step(inout longint integ, inout longint prev_err,
			input longint err, input logic [47:0] gains, input logic [47:0] elim,
			input logic [31:0] olim);
		longint kp, ki, kd, dead, ilim, itlim, outlim;
		longint e, mag, p_term, i_term, d_term, total;
		kp = {48'd0, gains[15:0]};
		ki = {48'd0, gains[31:16]};
		kd = {48'd0, gains[47:32]};
		dead = {48'd0, elim[15:0]};
		ilim = {32'd0, elim[47:16]};
		itlim = {48'd0, olim[15:0]};
		outlim = {48'd0, olim[31:16]};
		if (itlim > 32767)
			itlim = 32767;
		if (outlim > 32767)
			outlim = 32767;
		e = err;
		mag = (e < 0) ? -e : e;
		if (mag <= dead)
			e = 0;
		integ = sym_limit(integ + e, ilim);
		p_term = (kp * e) >>> GAIN_FRAC_BITS;
		i_term = sym_limit((ki * integ) >>> GAIN_FRAC_BITS, itlim);
		d_term = (kd * (e - prev_err)) >>> GAIN_FRAC_BITS;
		total = sym_limit(p_term + i_term + d_term, outlim);
		prev_err = e;
		return total;
	endfunction

	// Works out drive and outer output for one accepted item and advances the loop state.
	function automatic drive_result_t predict_drive(input logic signed [31:0] tgt,
			input logic signed [31:0] om, input logic signed [15:0] im);
		drive_result_t res;
		wrap_mode_e    wrap;
		longint        e, oout, drv;
		wrap = wrap_mode_e'(cfg_shadow[REG_WRAP_MODE][1:0]);
		e = longint'(tgt) - longint'(om);
		if (e > 64'sd2147483647)
			e = 64'sd2147483647;
		if (e < -64'sd2147483648)
			e = -64'sd2147483648;
		if (wrap == WRAP_TURN || wrap == WRAP_HALF_TURN)
			e = fold_turn(e, ENCODER_PERIOD);
		if (wrap == WRAP_HALF_TURN)
			e = fold_turn(e, ENCODER_PERIOD / 2);
		oout = loop_step(outer_integral, outer_last_err, e, cfg_shadow[REG_OUTER_GAINS],
			cfg_shadow[REG_OUTER_ERR_LIM], cfg_shadow[REG_OUTER_OUT_LIM][31:0]);
		drv = oout;
		if (cfg_shadow[REG_CASCADE][0])
			drv = loop_step(inner_integral, inner_last_err, oout - longint'(im),
				cfg_shadow[REG_INNER_GAINS], cfg_shadow[REG_INNER_ERR_LIM],
				cfg_shadow[REG_INNER_OUT_LIM][31:0]);
		res.drive = drv[15:0];
		res.outer_output = oout[15:0];
		return res;
	endfunction

	function automatic stim_row_t write_row(input cfg_reg_e r, input logic [47:0] v);
		stim_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.reg_idx = r;
		row.value = v;
		return row;
	endfunction

	function automatic stim_row_t item_row(input logic signed [31:0] tgt,
			input logic signed [31:0] om, input logic signed [15:0] im, input logic known,
			input logic signed [15:0] drv, input logic signed [15:0] oout);
		stim_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.target = tgt;
		row.outer_measure = om;
		row.inner_measure = im;
		row.known = known;
		row.want.drive = drv;
		row.want.outer_output = oout;
		return row;
	endfunction

	function automatic logic [15:0] random_gain();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 600));
		endcase
	endfunction

	function automatic logic [15:0] random_clamp();
		case ($urandom_range(0, 6))
			0: return 16'hFFFF;
			1: return 16'd32767;
			2: return 16'($urandom);
			3: return 16'd0;
			default: return 16'($urandom_range(0, 32767));
		endcase
	endfunction

	// Lowers valid, waits for every expected result, then lets the block settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_drive_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write transaction; valid stays high for a following write.
	task automatic write_reg(input cfg_reg_e r, input logic [47:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_shadow[r] = v;
		outer_integral = 0;
		outer_last_err = 0;
		inner_integral = 0;
		inner_last_err = 0;
	endtask

	// Sends one input transaction in bursts with random gaps and queues its expectation.
	task automatic send_item(input logic signed [31:0] tgt, input logic signed [31:0] om,
			input logic signed [15:0] im, input logic known, input drive_result_t want);
		int            gap;
		drive_result_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {im, om, tgt};
		do
			@(posedge clk);
		while (!s_tready);
		predicted = predict_drive(tgt, om, im);
		expected_drive_q.push_back(known ? want : predicted);
	endtask

	task automatic check_result(input logic [OUT_DATA_W-1:0] data);
		drive_result_t got;
		drive_result_t want;
		got = data;
		if (expected_drive_q.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("ERROR: unexpected result drive=%0d outer_output=%0d",
					got.drive, got.outer_output);
		end else begin
			want = expected_drive_q.pop_front();
			if (got.drive !== want.drive || got.outer_output !== want.outer_output) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("ERROR: expected drive=%0d outer_output=%0d, got drive=%0d outer_output=%0d",
						want.drive, want.outer_output, got.drive, got.outer_output);
			end
		end
	endtask

	// Receiver: checks each output transaction and stalls on a rotating ready pattern.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			check_result(m_tdata);
		if (pattern_age == 0) begin
			if ($urandom_range(0, 3) == 0)
				ready_pattern <= 16'hFFFF;
			else
				ready_pattern <= 16'($urandom) | 16'h0001;
			m_tready <= 1'b1;
		end else begin
			ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
			m_tready <= ready_pattern[15];
		end
		pattern_age <= pattern_age + 1'b1;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		stim_row_t          row;
		logic signed [31:0] tgt;
		logic signed [31:0] om;
		logic signed [15:0] im;
		logic [47:0]        value;
		logic               writing;
		int                 delta;

		for (int r = 0; r < 8; r++)
			cfg_shadow[r] = '0;
		outer_integral = 0;
		outer_last_err = 0;
		inner_integral = 0;
		inner_last_err = 0;

		// Directed table: zero gains after reset, then plain P terms that can be read off.
		directed_rows.push_back(item_row(32'sh7FFFFFFF, 32'sh80000000, 16'sh7FFF, 1, 0, 0));
		directed_rows.push_back(item_row(32'sh80000000, 32'sh7FFFFFFF, 16'sh8000, 1, 0, 0));
		directed_rows.push_back(write_row(REG_OUTER_GAINS, 48'h0000_0000_0100));
		// Clamps above range act as 32767.
		directed_rows.push_back(write_row(REG_OUTER_OUT_LIM, 48'h0000_FFFF_FFFF));
		directed_rows.push_back(item_row(100, 0, 0, 1, 100, 100));
		// Error saturates to 32 bits at both extremes.
		directed_rows.push_back(item_row(32'sh7FFFFFFF, 32'sh80000000, 0, 1, 32767, 32767));
		directed_rows.push_back(item_row(32'sh80000000, 32'sh7FFFFFFF, 0, 1, -32767, -32767));
		// Deadband of 10.
		directed_rows.push_back(write_row(REG_OUTER_ERR_LIM, 48'h0000_0000_000A));
		directed_rows.push_back(item_row(10, 0, 0, 1, 0, 0));
		directed_rows.push_back(item_row(-5, 6, 0, 1, -11, -11));
		// Folding by a full turn.
		directed_rows.push_back(write_row(REG_WRAP_MODE, WRAP_TURN));
		directed_rows.push_back(item_row(8000, 0, 0, 1, -191, -191));
		directed_rows.push_back(item_row(0, 4096, 0, 1, 4095, 4095));
		directed_rows.push_back(item_row(4095, 0, 0, 1, 4095, 4095));
		// Full turn, then half turn.
		directed_rows.push_back(write_row(REG_WRAP_MODE, WRAP_HALF_TURN));
		directed_rows.push_back(item_row(4095, 0, 0, 1, 0, 0));
		directed_rows.push_back(item_row(2048, 0, 0, 1, -2047, -2047));
		// The spare wrap mode folds nothing.
		directed_rows.push_back(write_row(REG_WRAP_MODE, WRAP_SPARE));
		directed_rows.push_back(item_row(8000, 0, 0, 1, 8000, 8000));
		// Cascade with zero inner gains, then a unity inner P term.
		directed_rows.push_back(write_row(REG_CASCADE, 48'd1));
		directed_rows.push_back(item_row(500, 0, 7, 1, 0, 500));
		directed_rows.push_back(write_row(REG_INNER_GAINS, 48'h0000_0000_0100));
		directed_rows.push_back(write_row(REG_INNER_OUT_LIM, 48'h0000_7FFF_7FFF));
		directed_rows.push_back(item_row(500, 0, 123, 1, 377, 500));
		directed_rows.push_back(item_row(500, 0, 16'sh8000, 1, 32767, 500));
		// Integral and derivative paths, checked by the predictor.
		directed_rows.push_back(write_row(REG_OUTER_GAINS, 48'h0200_0040_0080));
		directed_rows.push_back(write_row(REG_OUTER_ERR_LIM, 48'h0000_03E8_0003));
		directed_rows.push_back(write_row(REG_OUTER_OUT_LIM, 48'h0000_00C8_0032));
		directed_rows.push_back(write_row(REG_INNER_ERR_LIM, 48'hFFFF_FFFF_0000));
		directed_rows.push_back(item_row(300, 0, 0, 0, 0, 0));
		directed_rows.push_back(item_row(300, 100, -50, 0, 0, 0));
		directed_rows.push_back(item_row(-700, 0, 20, 0, 0, 0));
		directed_rows.push_back(item_row(-5, -5, 0, 0, 0, 0));
		directed_rows.push_back(item_row(2, 0, 0, 0, 0, 0));
		directed_rows.push_back(item_row(1000, -1000, 100, 0, 0, 0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; a group of writes waits for the block to go idle.
		writing = 1'b0;
		for (int n = 0; n < directed_rows.size(); n++) begin
			row = directed_rows[n];
			if (row.kind == ROW_WRITE) begin
				if (!writing)
					wait_idle();
				writing = 1'b1;
				write_reg(row.reg_idx, row.value);
			end else begin
				if (writing)
					cfg_valid <= 1'b0;
				writing = 1'b0;
				send_item(row.target, row.outer_measure, row.inner_measure, row.known,
					row.want);
			end
		end

		// Random phases: all ones, all zeros, then random settings of every register.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			for (int r = 0; r < 8; r++) begin
				if (phase == 0) begin
					value = '1;
				end else if (phase == 1) begin
					value = '0;
				end else begin
					case (cfg_reg_e'(r))
						REG_OUTER_GAINS, REG_INNER_GAINS: begin
							value = {random_gain(), random_gain(), random_gain()};
						end
						REG_OUTER_ERR_LIM, REG_INNER_ERR_LIM: begin
							case ($urandom_range(0, 4))
								0: value[15:0] = 16'd0;
								1: value[15:0] = 16'hFFFF;
								2: value[15:0] = 16'($urandom);
								default: value[15:0] = 16'($urandom_range(0, 40));
							endcase
							case ($urandom_range(0, 4))
								0: value[47:16] = 32'd0;
								1: value[47:16] = 32'hFFFF_FFFF;
								2: value[47:16] = $urandom;
								default: value[47:16] = $urandom_range(0, 20000);
							endcase
						end
						REG_OUTER_OUT_LIM, REG_INNER_OUT_LIM: begin
							value = {16'($urandom), random_clamp(), random_clamp()};
						end
						default: begin
							if ($urandom_range(0, 4) == 0)
								value = {16'($urandom), 32'($urandom)};
							else
								value = $urandom_range(0, 3);
						end
					endcase
				end
				write_reg(cfg_reg_e'(r), value);
			end
			cfg_valid <= 1'b0;

			// Mostly small errors that exercise the loops, with wrap-range and raw values.
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				case ($urandom_range(0, 9))
					0: begin
						tgt = $urandom;
						om = $urandom;
					end
					1: begin
						case ($urandom_range(0, 3))
							0: tgt = 32'sh7FFFFFFF;
							1: tgt = 32'sh80000000;
							2: tgt = 0;
							default: tgt = -1;
						endcase
						case ($urandom_range(0, 3))
							0: om = 32'sh7FFFFFFF;
							1: om = 32'sh80000000;
							2: om = 0;
							default: om = 1;
						endcase
					end
					2, 3: begin
						delta = int'($urandom_range(0, 24000)) - 12000;
						tgt = $urandom;
						om = tgt - delta;
					end
					default: begin
						delta = int'($urandom_range(0, 1200)) - 600;
						tgt = $urandom;
						om = tgt - delta;
					end
				endcase
				if ($urandom_range(0, 3) == 0)
					im = 16'($urandom);
				else
					im = 16'(int'($urandom_range(0, 1200)) - 600);
				send_item(tgt, om, im, 1'b0, '0);
			end
		end

		wait_idle();
		if (mismatch_count == 0 && expected_drive_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
src/cpid_pkg.sv
src/cpid_cfg_regs.sv
src/cpid_mul.sv
src/cascade_pid_controller.sv
verif/tb_cascade_pid_controller.sv
